[src/terminal_line_editor_defines.svh]
// Assertion macros shared by the terminal line editor RTL.
`ifndef TERMINAL_LINE_EDITOR_DEFINES_SVH
`define TERMINAL_LINE_EDITOR_DEFINES_SVH

// Plain property check on the rising clock, held off during reset.
`define TLE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Next-cycle implication check on the rising clock, held off during reset.
`define TLE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/tle_pkg.sv]
// Constants, echo codes and echo byte selection for the terminal line editor.
package tle_pkg;

  localparam int unsigned LINE_DEPTH = 2048;
  localparam int unsigned ADDR_W     = $clog2(LINE_DEPTH);
  localparam int unsigned CUR_W      = $clog2(LINE_DEPTH + 1);

  localparam logic [7:0] CH_ESC     = 8'd27;
  localparam logic [7:0] CH_BRACKET = 8'd91;
  localparam logic [7:0] CH_RIGHT   = 8'd67;
  localparam logic [7:0] CH_LEFT    = 8'd68;
  localparam logic [7:0] CH_THREE   = 8'd51;
  localparam logic [7:0] CH_TILDE   = 8'd126;
  localparam logic [7:0] CH_CR      = 8'd13;
  localparam logic [7:0] CH_DEL     = 8'd127;
  localparam logic [7:0] CH_BS      = 8'd8;
  localparam logic [7:0] CH_SPACE   = 8'd32;
  localparam logic [7:0] CH_LF      = 8'd10;

  // escape sequence phase
  localparam logic [1:0] PH_IDLE    = 2'd0;
  localparam logic [1:0] PH_ESC     = 2'd1;
  localparam logic [1:0] PH_BRACKET = 2'd2;
  localparam logic [1:0] PH_THREE   = 2'd3;

  // echo pattern of one input byte
  localparam logic [2:0] ECHO_NONE  = 3'd0;
  localparam logic [2:0] ECHO_CHAR  = 3'd1;  // the byte itself
  localparam logic [2:0] ECHO_MEM   = 3'd2;  // stored char under cursor
  localparam logic [2:0] ECHO_CRLF  = 3'd3;  // CR LF
  localparam logic [2:0] ECHO_BS    = 3'd4;  // BS
  localparam logic [2:0] ECHO_BLANK = 3'd5;  // SP BS
  localparam logic [2:0] ECHO_DEL   = 3'd6;  // BS SP BS

  function automatic logic [1:0] echo_count(input logic [2:0] kind);
    logic [1:0] n;
    unique case (kind)
      ECHO_CHAR, ECHO_MEM, ECHO_BS: n = 2'd1;
      ECHO_CRLF, ECHO_BLANK:        n = 2'd2;
      ECHO_DEL:                     n = 2'd3;
      default:                      n = 2'd0;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] echo_byte(input logic [2:0] kind, input logic [1:0] idx,
                                           input logic [7:0] chr, input logic [7:0] mem);
    logic [7:0] b;
    unique case (kind)
      ECHO_CHAR:  b = chr;
      ECHO_MEM:   b = mem;
      ECHO_CRLF:  b = (idx == 2'd0) ? CH_CR : CH_LF;
      ECHO_BLANK: b = (idx == 2'd0) ? CH_SPACE : CH_BS;
      ECHO_DEL:   b = (idx == 2'd1) ? CH_SPACE : CH_BS;
      default:    b = CH_BS;
    endcase
    return b;
  endfunction

endpackage

[src/terminal_line_editor.sv]
// Terminal line editor top level: escape decoding, cursor state and echo output.
//
// Input stream (s_axis): one received terminal byte per word in tdata.
// Output stream (m_axis): echo bytes in tdata; tlast marks the final echo
// byte caused by one input byte. An input causes zero to three echo words.
// The line characters live in a 2048 x 8 memory with a registered
// read; cursor, line length and escape phase are flip-flops updated when a
// byte is accepted, so every memory write lands in that same cycle.
// The first echo word is valid the cycle after the input is taken.
// One input per cycle when each gives at most one echo word and m_axis_tready_i
// is high; in general an input holds the echo stage until all of its echo words
// (at most three) are accepted, and the next input is taken in the cycle the
// last of those words is accepted. Inputs that echo nothing skip the echo stage.
// The ESC [ C echo comes straight from the memory read data register.
// Reset clears cursor, length, escape phase and the echo stage; the line
// memory is not cleared, and only entries below the length are ever read.
// When m_axis_tready_i is low the pending echo word holds and s_axis_tready_o
// stays low until the last echo word of the current input is taken.
`include "terminal_line_editor_defines.svh"

module terminal_line_editor import tle_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] rx_byte
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // [7:0] tx_byte
  output logic       m_axis_tlast_o
);

  logic [1:0]       phase_q, phase_d;
  logic [CUR_W-1:0] cursor_q, cursor_d;
  logic [CUR_W-1:0] len_q, len_d;

  logic             s1_valid_q;
  logic [2:0]       s1_kind_q;
  logic [1:0]       s1_idx_q;
  logic [7:0]       s1_chr_q;

  logic             accept;
  logic             s1_last;
  logic             s1_done;
  logic [2:0]       kind;
  logic             we;
  logic [ADDR_W-1:0] waddr;
  logic [7:0]       wdata;
  logic             re;
  logic [7:0]       rdata;

  logic [7:0]       c;
  logic             at_end;
  logic             before_len;
  logic             at_zero;

  assign c          = s_axis_tdata_i;
  assign at_end     = (cursor_q == CUR_W'(LINE_DEPTH));
  assign before_len = (cursor_q < len_q);
  assign at_zero    = (cursor_q == '0);

  assign s1_last         = (s1_idx_q == echo_count(s1_kind_q) - 2'd1);
  assign s1_done         = s1_valid_q && m_axis_tready_i && s1_last;
  assign s_axis_tready_o = !s1_valid_q || s1_done;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    phase_d  = phase_q;
    cursor_d = cursor_q;
    len_d    = len_q;
    kind     = ECHO_NONE;
    we       = 1'b0;
    waddr    = cursor_q[ADDR_W-1:0];
    wdata    = c;
    re       = 1'b0;
    if (accept) begin
      if (phase_q != PH_IDLE) begin
        phase_d = PH_IDLE;
        priority if (phase_q == PH_ESC && c == CH_BRACKET) begin
          phase_d = PH_BRACKET;
        end else if (phase_q == PH_BRACKET && c == CH_RIGHT) begin
          if (before_len) begin
            re       = 1'b1;
            kind     = ECHO_MEM;
            cursor_d = cursor_q + 1'b1;
          end
        end else if (phase_q == PH_BRACKET && c == CH_LEFT) begin
          if (!at_zero) begin
            kind     = ECHO_BS;
            cursor_d = cursor_q - 1'b1;
          end
        end else if (phase_q == PH_BRACKET && c == CH_THREE) begin
          phase_d = PH_THREE;
        end else if (phase_q == PH_THREE && c == CH_TILDE) begin
          if (before_len) begin
            we    = 1'b1;
            wdata = CH_SPACE;
            kind  = ECHO_BLANK;
          end
        end else begin
          phase_d = PH_IDLE;
        end
      end else if (c == CH_DEL) begin
        if (!at_zero) begin
          cursor_d = cursor_q - 1'b1;
          we       = 1'b1;
          waddr    = cursor_d[ADDR_W-1:0];
          wdata    = CH_SPACE;
          kind     = ECHO_DEL;
        end
      end else if (c == CH_ESC) begin
        phase_d = PH_ESC;
      end else if (!at_end) begin
        // CR and ordinary bytes both store at the cursor
        we       = 1'b1;
        kind     = (c == CH_CR) ? ECHO_CRLF : ECHO_CHAR;
        cursor_d = cursor_q + 1'b1;
        if (cursor_q == len_q) begin
          len_d = len_q + 1'b1;
        end
      end
    end
  end

  tle_line_ram #(
    .DEPTH (LINE_DEPTH),
    .WIDTH (8)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (cursor_q[ADDR_W-1:0]),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      cursor_q <= '0;
      len_q    <= '0;
    end else begin
      phase_q  <= phase_d;
      cursor_q <= cursor_d;
      len_q    <= len_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_kind_q  <= ECHO_NONE;
      s1_idx_q   <= '0;
    end else if (accept && kind != ECHO_NONE) begin
      s1_valid_q <= 1'b1;
      s1_kind_q  <= kind;
      s1_idx_q   <= '0;
    end else if (s1_done) begin
      s1_valid_q <= 1'b0;
    end else if (s1_valid_q && m_axis_tready_i) begin
      s1_idx_q <= s1_idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_chr_q <= c;
    end
  end

  assign m_axis_tvalid_o = s1_valid_q;
  assign m_axis_tdata_o  = echo_byte(s1_kind_q, s1_idx_q, s1_chr_q, rdata);
  assign m_axis_tlast_o  = s1_last;

  `TLE_ASSERT(a_cursor_in_line, cursor_q <= len_q, "cursor beyond line length")
  `TLE_ASSERT(a_len_in_depth, len_q <= CUR_W'(LINE_DEPTH), "line length beyond depth")
  `TLE_ASSERT_NEXT(a_broken_esc, accept && phase_q == PH_ESC && c != CH_BRACKET,
                   phase_q == PH_IDLE && !s1_valid_q, "broken sequence not dropped")

endmodule

[src/tle_line_ram.sv]
// Single-port-write, registered-read line character memory.
module tle_line_ram #(
  parameter int unsigned DEPTH  = 2048,
  parameter int unsigned WIDTH  = 8,
  parameter int unsigned AW     = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
